/* sv/carws_pkg.sv */
// Shared types and constants of the class-A receive window sequencer.
// No dependencies; every other file imports this package.
package carws_pkg;

    // Fixed field widths
    localparam int CMD_BITS      = 3;
    localparam int DEST_BITS     = 32;
    localparam int WIN_BITS      = 16;
    localparam int DL_BITS       = WIN_BITS + 2;   // sum of four windows
    localparam int SEQ_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Parameter defaults
    localparam int ADDR_BITS_DEF = 32;
    localparam int TICK_BITS_DEF = 18;

    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(1000);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_OWN_ADDR = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WAIT1    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_LISTEN1  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_WAIT2    = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_LISTEN2  = CFG_IDX_BITS'(4);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_TX      = 3'd1,
        ST_WAIT1   = 3'd2,
        ST_LISTEN1 = 3'd3,
        ST_RECV1   = 3'd4,
        ST_WAIT2   = 3'd5,
        ST_LISTEN2 = 3'd6,
        ST_RECV2   = 3'd7
    } mac_state_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK   = 3'd0,
        CMD_SEND   = 3'd1,
        CMD_TXDONE = 3'd2,
        CMD_MEDIUM = 3'd3,
        CMD_FRAME  = 3'd4,
        CMD_DROP   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        RM_SLEEP = 2'd0,
        RM_TX    = 2'd1,
        RM_RX    = 2'd2
    } radio_mode_t;

    typedef struct packed {
        logic [DEST_BITS-1:0] own_address;
        logic [WIN_BITS-1:0]  wait1_ticks;
        logic [WIN_BITS-1:0]  listen1_ticks;
        logic [WIN_BITS-1:0]  wait2_ticks;
        logic [WIN_BITS-1:0]  listen2_ticks;
    } carws_cfg_t;

    typedef struct packed {
        mac_state_t          mac_state;
        radio_mode_t         radio_mode;
        logic                send_frame;
        logic [SEQ_BITS-1:0] seq_number;
        logic                deliver_frame;
        logic                discard_frame;
        logic                bad_request;
    } carws_res_t;

endpackage

/* sv/carws_if.sv */
// Channel interfaces of the sequencer: event words in, result words out, config writes.
// Depends on carws_pkg for field widths.
interface carws_in_if;
    import carws_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_BITS-1:0]  cmd;
    logic                 receiving;
    logic [DEST_BITS-1:0] dest_addr;

    modport source (output valid, cmd, receiving, dest_addr, input ready);
    modport sink   (input valid, cmd, receiving, dest_addr, output ready);
endinterface

interface carws_out_if;
    import carws_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          mac_state;
    logic [1:0]          radio_mode;
    logic                send_frame;
    logic [SEQ_BITS-1:0] seq_number;
    logic                deliver_frame;
    logic                discard_frame;
    logic                bad_request;

    modport source (output valid, mac_state, radio_mode, send_frame, seq_number,
                    deliver_frame, discard_frame, bad_request, input ready);
    modport sink   (input valid, mac_state, radio_mode, send_frame, seq_number,
                    deliver_frame, discard_frame, bad_request, output ready);
endinterface

interface carws_cfg_if;
    import carws_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/carws_fsm.sv */
// MAC state machine and its timer, radio mode and sequence registers.
// Depends on carws_pkg. Updates once per word when step is high.
module carws_fsm
    import carws_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  cmd_t                 cmd,
    input  logic                 receiving,
    input  logic [DEST_BITS-1:0] dest_addr,
    input  carws_cfg_t           cfg,
    output carws_res_t           res
);

    localparam int CMP_BITS = (ADDR_BITS < DEST_BITS) ? ADDR_BITS : DEST_BITS;
    localparam int CMP_W    = (TICK_BITS > DL_BITS) ? TICK_BITS : DL_BITS;
    localparam logic [CMP_W-1:0] LIM_EXT = CMP_W'({TICK_BITS{1'b1}});

    mac_state_t           state_reg, state_next, state_mid, dl_state;
    logic [TICK_BITS-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic                 armed_reg, armed_next;
    logic                 was_rx_reg, was_rx_next;
    logic [SEQ_BITS-1:0]  nseq_reg, nseq_next;
    radio_mode_t          rmode_reg, rmode_next, rmode_pre;

    logic [DL_BITS-1:0]   sum1, sum2, sum3, sum4, dl_sum;
    logic [CMP_W-1:0]     dl_ext, dl_clamped;
    logic                 has_dl, moved, entered, addr_match;
    logic                 ev_send, ev_arm, ev_deliver, ev_discard, ev_bad;

    // Cumulative window deadlines
    assign sum1 = DL_BITS'(cfg.wait1_ticks);
    assign sum2 = sum1 + DL_BITS'(cfg.listen1_ticks);
    assign sum3 = sum2 + DL_BITS'(cfg.wait2_ticks);
    assign sum4 = sum3 + DL_BITS'(cfg.listen2_ticks);

    // Saturating tick counter
    assign elapsed_inc = (cmd == CMD_TICK && armed_reg && elapsed_reg != {TICK_BITS{1'b1}})
                       ? elapsed_reg + TICK_BITS'(1) : elapsed_reg;

    always_comb
    begin
        has_dl   = 1'b1;
        dl_sum   = '0;
        dl_state = ST_IDLE;
        case (state_reg)
            ST_WAIT1:   begin dl_sum = sum1; dl_state = ST_LISTEN1; end
            ST_LISTEN1: begin dl_sum = sum2; dl_state = ST_WAIT2;   end
            ST_WAIT2:   begin dl_sum = sum3; dl_state = ST_LISTEN2; end
            ST_LISTEN2: begin dl_sum = sum4; dl_state = ST_IDLE;    end
            default:    has_dl = 1'b0;
        endcase
    end

    assign dl_ext     = CMP_W'(dl_sum);
    assign dl_clamped = (dl_ext > LIM_EXT) ? LIM_EXT : dl_ext;
    assign moved      = has_dl && (CMP_W'(elapsed_inc) >= dl_clamped);
    assign state_mid  = moved ? dl_state : state_reg;
    assign addr_match = dest_addr[CMP_BITS-1:0] == cfg.own_address[CMP_BITS-1:0];

    // Next state; a passed deadline blocks any command transition
    always_comb
    begin
        state_next = state_mid;
        entered    = moved;
        ev_send    = 1'b0;
        ev_arm     = 1'b0;
        ev_deliver = 1'b0;
        ev_discard = 1'b0;
        ev_bad     = 1'b0;
        case (cmd)
            CMD_SEND:
            begin
                if (state_mid == ST_IDLE && !moved)
                begin
                    state_next = ST_TX;
                    entered    = 1'b1;
                    ev_send    = 1'b1;
                end
                else
                begin
                    ev_bad = 1'b1;
                end
            end
            CMD_TXDONE:
            begin
                if (!moved && state_mid == ST_TX)
                begin
                    state_next = ST_WAIT1;
                    entered    = 1'b1;
                    ev_arm     = 1'b1;
                end
            end
            CMD_MEDIUM:
            begin
                if (!moved && receiving && state_mid == ST_LISTEN1)
                begin
                    state_next = ST_RECV1;
                    entered    = 1'b1;
                end
                else if (!moved && receiving && state_mid == ST_LISTEN2)
                begin
                    state_next = ST_RECV2;
                    entered    = 1'b1;
                end
            end
            CMD_FRAME:
            begin
                if (state_mid == ST_RECV1 || state_mid == ST_RECV2)
                begin
                    entered = 1'b1;
                    if (addr_match)
                    begin
                        state_next = ST_IDLE;
                        ev_deliver = 1'b1;
                    end
                    else
                    begin
                        state_next = (state_mid == ST_RECV1) ? ST_LISTEN1 : ST_LISTEN2;
                        ev_discard = 1'b1;
                    end
                end
                else
                begin
                    ev_discard = 1'b1;
                end
            end
            CMD_DROP:
            begin
                if (state_mid == ST_RECV1)
                begin
                    state_next = ST_LISTEN1;
                    entered    = 1'b1;
                end
                else if (state_mid == ST_RECV2)
                begin
                    state_next = ST_LISTEN2;
                    entered    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs and datapath register updates
    always_comb
    begin
        rmode_pre = rmode_reg;
        if (cmd == CMD_MEDIUM && was_rx_reg)
            rmode_pre = RM_SLEEP;
        else if (cmd == CMD_DROP)
            rmode_pre = RM_SLEEP;

        rmode_next = rmode_pre;
        if (entered)
        begin
            case (state_next)
                ST_IDLE, ST_WAIT1, ST_WAIT2: rmode_next = RM_SLEEP;
                ST_TX:                       rmode_next = RM_TX;
                ST_LISTEN1, ST_LISTEN2:      rmode_next = RM_RX;
                default:                     rmode_next = rmode_pre;
            endcase
        end
        if (cmd == CMD_TXDONE)
            rmode_next = RM_SLEEP;

        was_rx_next  = (cmd == CMD_MEDIUM) ? receiving : was_rx_reg;
        elapsed_next = ev_arm ? '0 : elapsed_inc;
        if (ev_arm)
            armed_next = 1'b1;
        else if ((moved && dl_state == ST_IDLE) || ev_deliver)
            armed_next = 1'b0;
        else
            armed_next = armed_reg;
        nseq_next = ev_send ? nseq_reg + SEQ_BITS'(1) : nseq_reg;

        res.mac_state     = state_next;
        res.radio_mode    = rmode_next;
        res.send_frame    = ev_send;
        res.seq_number    = ev_send ? nseq_reg : '0;
        res.deliver_frame = ev_deliver;
        res.discard_frame = ev_discard;
        res.bad_request   = ev_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            armed_reg   <= 1'b0;
            was_rx_reg  <= 1'b0;
            nseq_reg    <= '0;
            rmode_reg   <= RM_SLEEP;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            armed_reg   <= armed_next;
            was_rx_reg  <= was_rx_next;
            nseq_reg    <= nseq_next;
            rmode_reg   <= rmode_next;
        end
    end

    // At most one event pulse per word
    a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({res.send_frame, res.deliver_frame, res.discard_frame, res.bad_request}))
        else $error("more than one event pulse in a word");

    // A send moves to transmit and uses exactly one sequence number
    a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.send_frame |=> state_reg == ST_TX && nseq_reg == $past(nseq_reg) + 1'b1)
        else $error("send did not enter transmit or advance sequence");

    // Timers run exactly in the window states
    a_armed_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg == (state_reg != ST_IDLE && state_reg != ST_TX))
        else $error("timer arm flag out of step with state");

    // Counter holds while disarmed unless it is being armed
    a_counter_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |=> armed_reg || $stable(elapsed_reg))
        else $error("elapsed counter moved while disarmed");

endmodule

/* sv/class_a_rx_window_sequencer.sv */
// Class-A receive window sequencer. Each event word (tick, send request, transmit
// done, medium change, frame received, frame dropped) yields exactly one result word
// with the MAC state, radio mode and event pulses after that event. Throughput is one
// word per clock while rsp ready is high; the state registers in carws_fsm update once
// per word. A word passes an input register and then a result register, which it
// enters once the result slot is free or its result is being taken. The result
// register lets the next word enter while a result waits; with both registers full
// and rsp ready low, req ready drops. Window lengths must be set through the
// config channel while no word is in flight; the block itself does not enforce it.
// Depends on carws_pkg, carws_if and carws_fsm.
module class_a_rx_window_sequencer
    import carws_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,   // address bits compared
    parameter int TICK_BITS = TICK_BITS_DEF    // elapsed counter width
)
(
    input logic        clk,
    input logic        rst_n,
    carws_in_if.sink   req,
    carws_out_if.source rsp,
    carws_cfg_if.sink  cfg
);

    // Input stage
    logic                 s1_valid_reg;
    logic [CMD_BITS-1:0]  cmd_reg;
    logic                 receiving_reg;
    logic [DEST_BITS-1:0] dest_addr_reg;

    // Result stage
    logic       out_valid_reg;
    carws_res_t result_reg;
    carws_res_t result_next;

    // Configuration registers
    logic [DEST_BITS-1:0] own_address_reg;
    logic [WIN_BITS-1:0]  wait1_reg, listen1_reg, wait2_reg, listen2_reg;
    carws_cfg_t           cfg_bus;

    logic advance;

    // Word moves from input stage to result stage when the result slot frees up
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg       <= req.cmd;
            receiving_reg <= req.receiving;
            dest_addr_reg <= req.dest_addr;
        end
    end

    // Config writes; indexes past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            wait1_reg       <= WIN_RESET;
            listen1_reg     <= WIN_RESET;
            wait2_reg       <= WIN_RESET;
            listen2_reg     <= WIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_OWN_ADDR: own_address_reg <= DEST_BITS'(cfg.data);
                REG_WAIT1:    wait1_reg       <= cfg.data[WIN_BITS-1:0];
                REG_LISTEN1:  listen1_reg     <= cfg.data[WIN_BITS-1:0];
                REG_WAIT2:    wait2_reg       <= cfg.data[WIN_BITS-1:0];
                REG_LISTEN2:  listen2_reg     <= cfg.data[WIN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_bus.own_address   = own_address_reg;
    assign cfg_bus.wait1_ticks   = wait1_reg;
    assign cfg_bus.listen1_ticks = listen1_reg;
    assign cfg_bus.wait2_ticks   = wait2_reg;
    assign cfg_bus.listen2_ticks = listen2_reg;

    // State machine: combinational step from registered word, state commits on advance
    carws_fsm #(
        .ADDR_BITS (ADDR_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cmd       (cmd_t'(cmd_reg)),
        .receiving (receiving_reg),
        .dest_addr (dest_addr_reg),
        .cfg       (cfg_bus),
        .res       (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.mac_state     = result_reg.mac_state;
    assign rsp.radio_mode    = result_reg.radio_mode;
    assign rsp.send_frame    = result_reg.send_frame;
    assign rsp.seq_number    = result_reg.seq_number;
    assign rsp.deliver_frame = result_reg.deliver_frame;
    assign rsp.discard_frame = result_reg.discard_frame;
    assign rsp.bad_request   = result_reg.bad_request;

endmodule

/* bench/class_a_rx_window_sequencer_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for class_a_rx_window_sequencer: directed walk plus random MAC sessions.
// Depends on carws_pkg, carws_if (channel interfaces) and the sequencer RTL.
module class_a_rx_window_sequencer_test;
    import carws_pkg::*;

    // Spare command codes: the block treats them as no event
    localparam logic [CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

    localparam logic [TICK_BITS_DEF-1:0] TICK_TOP = '1;   // elapsed counter saturation
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 48;                      // receiver hold-off, cycles
    localparam logic [DEST_BITS-1:0] FLOW_ADDR = 32'h5A0F_C3A1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    carws_in_if  req_ch ();
    carws_out_if rsp_ch ();
    carws_cfg_if cfg_ch ();

    class_a_rx_window_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predicted MAC state and register shadow
    // ------------------------------------------------------------------
    mac_state_t                 st;
    logic [TICK_BITS_DEF-1:0]   ticks;
    bit                         armed;
    bit                         rx_busy;      // last reported medium state
    logic [SEQ_BITS-1:0]        seq_next;
    radio_mode_t                radio;

    logic [DEST_BITS-1:0]       addr_cfg;
    logic [WIN_BITS-1:0]        w1_cfg, l1_cfg, w2_cfg, l2_cfg;

    carws_res_t results_due[$];   // predicted result words, oldest first

    // Run control shared by the stimulus, the receiver and the checker
    bit          idle_en    = 1'b1;
    bit          hold_ask   = 1'b0;
    int unsigned burst_left = 0;    // words left to send back to back
    int unsigned cycles     = 0;
    int unsigned miss_count = 0;
    int unsigned words_in   = 0;
    int unsigned settings   = 0;
    int unsigned sent_total = 0;
    int unsigned dlv_total  = 0;
    int unsigned bad_total  = 0;

    // Entering a state sets the radio, except for the receiving states
    function automatic void go_to(mac_state_t s);
        st = s;
        case (s)
            ST_IDLE, ST_WAIT1, ST_WAIT2: radio = RM_SLEEP;
            ST_TX:                       radio = RM_TX;
            ST_LISTEN1, ST_LISTEN2:      radio = RM_RX;
            default: ;
        endcase
    endfunction

    // One event word in, one result word out; updates the predicted state.
    function automatic carws_res_t advance_mac(input logic [CMD_BITS-1:0] op,
                                               input logic rx_now,
                                               input logic [DEST_BITS-1:0] dest);
        carws_res_t  r;
        int unsigned due;
        bit          timed;
        bit          moved;
        mac_state_t  nxt;
        r     = '0;
        due   = 0;
        timed = 1'b1;
        nxt   = ST_IDLE;

        if (op == CMD_TICK && armed && ticks != TICK_TOP)
            ticks++;

        // Medium and drop events act on the radio before the deadline check
        if (op == CMD_MEDIUM)
        begin
            if (rx_busy)
                radio = RM_SLEEP;
            rx_busy = rx_now;
        end
        else if (op == CMD_DROP)
            radio = RM_SLEEP;

        // Cumulative deadlines; a passed one wins over the event
        case (st)
            ST_WAIT1:
            begin
                due = int'(w1_cfg);
                nxt = ST_LISTEN1;
            end
            ST_LISTEN1:
            begin
                due = int'(w1_cfg) + int'(l1_cfg);
                nxt = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                due = int'(w1_cfg) + int'(l1_cfg) + int'(w2_cfg);
                nxt = ST_LISTEN2;
            end
            ST_LISTEN2:
            begin
                due = int'(w1_cfg) + int'(l1_cfg) + int'(w2_cfg) + int'(l2_cfg);
                nxt = ST_IDLE;
            end
            default: timed = 1'b0;
        endcase
        if (due > int'(TICK_TOP))
            due = int'(TICK_TOP);
        moved = timed && (ticks >= due);
        if (moved)
        begin
            if (nxt == ST_IDLE)
                armed = 1'b0;
            go_to(nxt);
        end

        case (op)
            CMD_SEND:
                if (st == ST_IDLE && !moved)
                begin
                    r.send_frame = 1'b1;
                    r.seq_number = seq_next;
                    seq_next++;
                    go_to(ST_TX);
                end
                else
                    r.bad_request = 1'b1;
            CMD_TXDONE:
            begin
                if (!moved && st == ST_TX)
                begin
                    ticks = '0;
                    armed = 1'b1;
                    go_to(ST_WAIT1);
                end
                radio = RM_SLEEP;
            end
            CMD_MEDIUM:
                if (!moved && rx_now)
                begin
                    if (st == ST_LISTEN1)
                        go_to(ST_RECV1);
                    else if (st == ST_LISTEN2)
                        go_to(ST_RECV2);
                end
            CMD_FRAME:
                if (st == ST_RECV1 || st == ST_RECV2)
                begin
                    if (dest == addr_cfg)
                    begin
                        r.deliver_frame = 1'b1;
                        armed = 1'b0;
                        go_to(ST_IDLE);
                    end
                    else
                    begin
                        r.discard_frame = 1'b1;
                        go_to(st == ST_RECV1 ? ST_LISTEN1 : ST_LISTEN2);
                    end
                end
                else
                    r.discard_frame = 1'b1;
            CMD_DROP:
                if (st == ST_RECV1)
                    go_to(ST_LISTEN1);
                else if (st == ST_RECV2)
                    go_to(ST_LISTEN2);
            default: ;
        endcase

        r.mac_state  = st;
        r.radio_mode = radio;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed stimulus table
    // ------------------------------------------------------------------
    typedef struct {
        logic [CMD_BITS-1:0]  op;
        logic                 rx;
        logic [DEST_BITS-1:0] dest;
        bit                   reconfig;   // load the flow settings before this word
        bit                   typed;      // known holds the result read off by hand
        carws_res_t           known;
    } probe_t;

    probe_t probes[$];

    function automatic carws_res_t result_of(mac_state_t s, radio_mode_t m, bit snd,
                                             int unsigned sq, bit dlv, bit dsc, bit bad);
        carws_res_t r;
        r.mac_state     = s;
        r.radio_mode    = m;
        r.send_frame    = snd;
        r.seq_number    = SEQ_BITS'(sq);
        r.deliver_frame = dlv;
        r.discard_frame = dsc;
        r.bad_request   = bad;
        return r;
    endfunction

    function automatic probe_t row(logic [CMD_BITS-1:0] op, logic rx,
                                   logic [DEST_BITS-1:0] dest, bit reconfig,
                                   bit typed, carws_res_t known);
        probe_t p;
        p.op       = op;
        p.rx       = rx;
        p.dest     = dest;
        p.reconfig = reconfig;
        p.typed    = typed;
        p.known    = known;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch log: first ten in full, the rest only counted
    // ------------------------------------------------------------------
    function automatic void log_miss(string why, carws_res_t w, carws_res_t g);
        miss_count++;
        if (miss_count <= 10)
            $display("MISMATCH %s at cycle %0d: expected st=%0d rm=%0d snd=%0b seq=%0d dlv=%0b dsc=%0b bad=%0b, got st=%0d rm=%0d snd=%0b seq=%0d dlv=%0b dsc=%0b bad=%0b",
                     why, cycles,
                     w.mac_state, w.radio_mode, w.send_frame, w.seq_number,
                     w.deliver_frame, w.discard_frame, w.bad_request,
                     g.mac_state, g.radio_mode, g.send_frame, g.seq_number,
                     g.deliver_frame, g.discard_frame, g.bad_request);
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    carws_res_t seen, due_word;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("Verification failed");
            $finish;
        end
        else if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.mac_state     = mac_state_t'(rsp_ch.mac_state);
            seen.radio_mode    = radio_mode_t'(rsp_ch.radio_mode);
            seen.send_frame    = rsp_ch.send_frame;
            seen.seq_number    = rsp_ch.seq_number;
            seen.deliver_frame = rsp_ch.deliver_frame;
            seen.discard_frame = rsp_ch.discard_frame;
            seen.bad_request   = rsp_ch.bad_request;
            if (results_due.size() == 0)
                log_miss("unexpected word", '0, seen);
            else
            begin
                due_word = results_due.pop_front();
                if (seen !== due_word)
                    log_miss("field", due_word, seen);
            end
            if (seen.send_frame === 1'b1)
                sent_total++;
            if (seen.deliver_frame === 1'b1)
                dlv_total++;
            if (seen.bad_request === 1'b1)
                bad_total++;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int unsigned span;
        rsp_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                rsp_ch.ready <= 1'b0;
                span = LONG_HOLD;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                span = $urandom_range(1, 7);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                span = 1;
            end
            repeat (span) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offer one event word; valid is left high so the next word can follow
    // back to back. The expectation is queued at the accepting edge.
    task automatic send_word(input logic [CMD_BITS-1:0] op, input logic rx,
                             input logic [DEST_BITS-1:0] dest,
                             input bit typed, input carws_res_t known);
        carws_res_t predicted;
        if (idle_en && burst_left == 0 && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= op;
        req_ch.receiving <= rx;
        req_ch.dest_addr <= dest;
        do @(posedge clk); while (!req_ch.ready);
        predicted = advance_mac(op, rx, dest);
        results_due.push_back(typed ? known : predicted);
        words_in++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stop sending and let every pending result drain out
    task automatic settle_out();
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);   // two-stage pipe, plus margin
    endtask

    // Caller leaves cfg valid high between writes; set_config lowers it
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_OWN_ADDR: addr_cfg = val;
            REG_WAIT1:    w1_cfg   = val[WIN_BITS-1:0];
            REG_LISTEN1:  l1_cfg   = val[WIN_BITS-1:0];
            REG_WAIT2:    w2_cfg   = val[WIN_BITS-1:0];
            REG_LISTEN2:  l2_cfg   = val[WIN_BITS-1:0];
            default: ;
        endcase
    endtask

    // Only called with the block idle; drains first
    task automatic set_config(input logic [DEST_BITS-1:0] addr,
                              input logic [WIN_BITS-1:0] w1, input logic [WIN_BITS-1:0] l1,
                              input logic [WIN_BITS-1:0] w2, input logic [WIN_BITS-1:0] l2);
        settle_out();
        write_reg(REG_OWN_ADDR, addr);
        write_reg(REG_WAIT1,    {16'd0, w1});
        write_reg(REG_LISTEN1,  {16'd0, l1});
        write_reg(REG_WAIT2,    {16'd0, w2});
        write_reg(REG_LISTEN2,  {16'd0, l2});
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    // Random words, mostly well-formed sessions steered by the predicted
    // state, with some fully random noise mixed in.
    task automatic run_random(input int unsigned count);
        logic [CMD_BITS-1:0]  op;
        logic                 rx;
        logic [DEST_BITS-1:0] dest;
        int unsigned          roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            op   = CMD_BITS'($urandom_range(0, 7));
            rx   = 1'($urandom_range(0, 1));
            dest = $urandom;
            if (roll >= 15)
            begin
                case (st)
                    ST_IDLE:          op = CMD_SEND;
                    ST_TX:            op = CMD_TXDONE;
                    ST_WAIT1, ST_WAIT2: op = CMD_TICK;
                    ST_LISTEN1, ST_LISTEN2:
                        if (roll < 55)
                            op = CMD_TICK;
                        else
                        begin
                            op = CMD_MEDIUM;
                            rx = (roll < 92);
                        end
                    default:   // receiving
                        if (roll < 50)
                        begin
                            op   = CMD_FRAME;
                            dest = addr_cfg;
                        end
                        else if (roll < 70)
                            op = CMD_FRAME;
                        else if (roll < 85)
                            op = CMD_DROP;
                        else
                            op = CMD_TICK;
                endcase
            end
            send_word(op, rx, dest, 1'b0, '0);
        end
    endtask

    // Drive the session to idle so registers may be rewritten
    task automatic go_home();
        while (st != ST_IDLE)
        begin
            case (st)
                ST_TX:                  send_word(CMD_TXDONE, 1'b0, '0, 1'b0, '0);
                ST_LISTEN1, ST_LISTEN2: send_word(CMD_MEDIUM, 1'b1, '0, 1'b0, '0);
                ST_RECV1, ST_RECV2:     send_word(CMD_FRAME, 1'b0, addr_cfg, 1'b0, '0);
                default:                send_word(CMD_TICK, 1'b0, '0, 1'b0, '0);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= CMD_TICK;
        req_ch.receiving <= 1'b0;
        req_ch.dest_addr <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_OWN_ADDR;
        cfg_ch.data      <= '0;

        // Predictor and shadow start from the reset values
        st       = ST_IDLE;
        ticks    = '0;
        armed    = 1'b0;
        rx_busy  = 1'b0;
        seq_next = '0;
        radio    = RM_SLEEP;
        addr_cfg = '0;
        w1_cfg   = WIN_RESET;
        l1_cfg   = WIN_RESET;
        w2_cfg   = WIN_RESET;
        l2_cfg   = WIN_RESET;

        // Reset-config part: idle-state events only (windows of 1000 would
        // take a thousand ticks to leave wait1).
        probes.push_back(row(CMD_TICK,   0, '0, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 0, 0)));
        // frame while not receiving is discarded
        probes.push_back(row(CMD_FRAME,  0, 32'hFFFF_FFFF, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 1, 0)));
        probes.push_back(row(CMD_DROP,   0, '0, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 0, 0)));
        probes.push_back(row(CMD_MEDIUM, 1, '0, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 0, 0)));
        probes.push_back(row(CMD_MEDIUM, 0, '0, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 0, 0)));
        probes.push_back(row(CMD_SPARE6, 0, '0, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 0, 0)));
        probes.push_back(row(CMD_SPARE7, 1, 32'hFFFF_FFFF, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 0, 0, 0)));
        // Full session with short windows (2, 2, 1, 2)
        probes.push_back(row(CMD_SEND,   0, '0, 1, 1,
                             result_of(ST_TX, RM_TX, 1, 0, 0, 0, 0)));
        // send while busy is refused
        probes.push_back(row(CMD_SEND,   0, '0, 0, 1,
                             result_of(ST_TX, RM_TX, 0, 0, 0, 0, 1)));
        probes.push_back(row(CMD_TXDONE, 0, '0, 0, 1,
                             result_of(ST_WAIT1, RM_SLEEP, 0, 0, 0, 0, 0)));
        probes.push_back(row(CMD_TICK,   0, '0, 0, 0, '0));
        probes.push_back(row(CMD_TICK,   0, '0, 0, 0, '0));          // into listen1
        probes.push_back(row(CMD_MEDIUM, 1, '0, 0, 0, '0));          // recv1
        probes.push_back(row(CMD_FRAME,  0, ~FLOW_ADDR, 0, 1,
                             result_of(ST_LISTEN1, RM_RX, 0, 0, 0, 1, 0)));
        probes.push_back(row(CMD_MEDIUM, 1, '0, 0, 0, '0));          // radio sleeps
        probes.push_back(row(CMD_DROP,   0, '0, 0, 0, '0));          // back to listen1
        probes.push_back(row(CMD_TICK,   0, '0, 0, 0, '0));
        probes.push_back(row(CMD_MEDIUM, 1, '0, 0, 0, '0));
        probes.push_back(row(CMD_TICK,   0, '0, 0, 0, '0));          // deadline hit in recv1
        probes.push_back(row(CMD_DROP,   0, '0, 0, 0, '0));
        // passed deadline wins: listen1 -> wait2, and the send is refused
        probes.push_back(row(CMD_SEND,   0, '0, 0, 1,
                             result_of(ST_WAIT2, RM_SLEEP, 0, 0, 0, 0, 1)));
        probes.push_back(row(CMD_FRAME,  0, FLOW_ADDR, 0, 0, '0));   // wrong state
        probes.push_back(row(CMD_TICK,   0, '0, 0, 0, '0));          // into listen2
        probes.push_back(row(CMD_MEDIUM, 1, '0, 0, 0, '0));
        probes.push_back(row(CMD_FRAME,  0, FLOW_ADDR, 0, 1,
                             result_of(ST_IDLE, RM_SLEEP, 0, 0, 1, 0, 0)));
        probes.push_back(row(CMD_TXDONE, 0, '0, 0, 0, '0));          // stray done

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            if (probes[i].reconfig)
                set_config(FLOW_ADDR, 16'd2, 16'd2, 16'd1, 16'd2);
            send_word(probes[i].op, probes[i].rx, probes[i].dest,
                      probes[i].typed, probes[i].known);
        end
        go_home();

        // Short random windows; long receiver hold-off with the sender
        // pushing back to back, then a full drain mid-phase.
        set_config($urandom, WIN_BITS'($urandom_range(1, 5)), WIN_BITS'($urandom_range(1, 5)),
                   WIN_BITS'($urandom_range(1, 5)), WIN_BITS'($urandom_range(1, 5)));
        run_random(60);
        hold_ask   = 1'b1;
        burst_left = 30;
        run_random(60);
        settle_out();
        run_random(60);
        go_home();

        // All windows zero: every deadline passes on the next word
        set_config(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(80);
        go_home();

        // Mix of zero and short windows
        set_config($urandom, WIN_BITS'($urandom_range(0, 3)), WIN_BITS'($urandom_range(0, 3)),
                   WIN_BITS'($urandom_range(0, 3)), WIN_BITS'($urandom_range(0, 3)));
        run_random(80);
        go_home();

        // Widest windows; sessions end by delivery in window 1
        set_config(32'h0000_0000, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(80);
        go_home();

        // Final stretch at full rate on both sides
        idle_en = 1'b0;
        set_config($urandom, WIN_BITS'($urandom_range(1, 4)), WIN_BITS'($urandom_range(1, 4)),
                   WIN_BITS'($urandom_range(1, 4)), WIN_BITS'($urandom_range(1, 4)));
        run_random(200);
        go_home();

        req_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);   // catch any stray result words

        if (results_due.size() != 0)
        begin
            $display("%0d predicted results never arrived", results_due.size());
            miss_count += results_due.size();
        end

        $display("Run: %0d event words over %0d register settings, %0d mismatches.",
                 words_in, settings, miss_count);
        $display("Frames sent %0d, delivered %0d, refused send requests %0d.",
                 sent_total, dlv_total, bad_total);
        if (miss_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
